[design/efd_pkg.sv]
`timescale 1ns / 1ps

package efd_pkg;

    localparam int YEAR_W = 14;
    localparam int MON_W  = 4;
    localparam int DAY_W  = 5;
    localparam int DOY_W  = 8;

    localparam int STAGES = 8;

    localparam logic [15:0] RECIP19   = 16'd55189;
    localparam int          SHIFT19   = 20;
    localparam logic [12:0] RECIP100  = 13'd5243;
    localparam int          SHIFT100  = 19;
    localparam logic [5:0]  RECIP25   = 6'd41;
    localparam int          SHIFT25   = 10;
    localparam logic [7:0]  RECIP3    = 8'd171;
    localparam int          SHIFT3    = 9;
    localparam logic [9:0]  RECIP30   = 10'd547;
    localparam int          SHIFT30   = 14;
    localparam logic [7:0]  RECIP7    = 8'd147;
    localparam int          SHIFT7    = 10;

    localparam logic [8:0]  MJB_LIMIT = 9'd451;
    localparam logic [7:0]  MJB_BASE  = 8'd114;
    localparam logic [7:0]  MJB_PACT  = 8'd32;
    localparam logic [9:0]  MJB_EPACT = 10'd15;
    localparam logic [7:0]  APRIL_V   = 8'd124;
    localparam logic [7:0]  MARCH_V   = 8'd93;

    localparam logic [7:0]  OFS_FRIDAY    = 8'd2;
    localparam logic [7:0]  OFS_ASCENSION = 8'd39;
    localparam logic [7:0]  OFS_WHITSUN   = 8'd49;
    localparam logic [7:0]  OFS_CARNIVAL  = 8'd49;

    localparam logic [MON_W-1:0] MON_FEB = 4'd2;
    localparam logic [MON_W-1:0] MON_MAR = 4'd3;
    localparam logic [MON_W-1:0] MON_APR = 4'd4;

    localparam logic [8:0] CUM_END [12] = '{
        9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
    };

    localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic [MON_W-1:0] month;
        logic [DAY_W-1:0] day;
    } t_md;

    function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] mon,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        len = '0;
        if (mon inside {[4'd1:4'd12]}) begin
            len = MONTH_LEN[mon - 4'd1];
            if (mon == MON_FEB && leap) begin
                len = len + 5'd1;
            end
        end
        return len;
    endfunction

    function automatic t_md split_doy(input logic [DOY_W-1:0] doy, input logic leap);
        t_md       res;
        logic [8:0] bound;
        res.month = 4'd1;
        res.day   = doy[DAY_W-1:0];
        for (int m = 0; m < 11; m++) begin
            bound = CUM_END[m] + ((m >= 1) ? {8'd0, leap} : 9'd0);
            if ({1'b0, doy} > bound) begin
                res.month = MON_W'(m + 2);
                res.day   = DAY_W'({1'b0, doy} - bound);
            end
        end
        return res;
    endfunction

endpackage

[design/easter_feast_dates.sv]
`timescale 1ns / 1ps

// Easter and movable feast dates of a Gregorian year, plus a month-length query.
// Input channel: i_valid / o_stall with i_year_value and i_month_query; one beat
// per year. Output channel: o_valid / i_stall with the leap flag, the length of
// the queried month, and month/day of Easter, Good Friday, Ascension, Whitsunday
// and Carnival; one result beat per input beat, in order.
// Pipeline: eight register stages; a result is driven from the registers of the
// last stage and is taken when o_valid is high and i_stall is low.
// Throughput: one beat per cycle while i_stall is low, set by the pipeline
// registers between the constant-reciprocal divisions of the computus.
// Reset (i_rst_n low, synchronous) empties the pipeline; all valid bits clear.
// When the receiver stalls, the last stage holds its beat and the stages behind
// it keep filling empty slots; o_stall rises only once every stage holds a beat.
module easter_feast_dates
    import efd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [YEAR_W-1:0]   i_year_value,
    input  logic [MON_W-1:0]    i_month_query,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_leap_flag,
    output logic [DAY_W-1:0]    o_query_month_days,
    output logic [MON_W-1:0]    o_easter_month_out,
    output logic [DAY_W-1:0]    o_easter_day_out,
    output logic [MON_W-1:0]    o_friday_month,
    output logic [DAY_W-1:0]    o_friday_day,
    output logic [MON_W-1:0]    o_ascension_month,
    output logic [DAY_W-1:0]    o_ascension_day,
    output logic [MON_W-1:0]    o_whitsun_month,
    output logic [DAY_W-1:0]    o_whitsun_day,
    output logic [MON_W-1:0]    o_carnival_month,
    output logic [DAY_W-1:0]    o_carnival_day
);

    logic [STAGES-1:0] r_vld;
    logic [STAGES:0]   adv;

    // stage 1
    logic [4:0]  r1_a;
    logic [7:0]  r1_b;
    logic [6:0]  r1_c;
    logic [MON_W-1:0] r1_mq;
    logic        r1_y4;
    logic        r1_yz;
    // stage 2
    logic [4:0]  r2_a;
    logic [7:0]  r2_b;
    logic [5:0]  r2_d;
    logic [1:0]  r2_e;
    logic [2:0]  r2_f;
    logic [4:0]  r2_i;
    logic [1:0]  r2_k;
    logic        r2_leap;
    logic [DAY_W-1:0] r2_qd;
    // stage 3
    logic [4:0]  r3_a;
    logic [5:0]  r3_g;
    logic [9:0]  r3_hs;
    logic [1:0]  r3_e;
    logic [4:0]  r3_i;
    logic [1:0]  r3_k;
    logic        r3_leap;
    logic [DAY_W-1:0] r3_qd;
    // stage 4
    logic [4:0]  r4_a;
    logic [4:0]  r4_h;
    logic [1:0]  r4_e;
    logic [4:0]  r4_i;
    logic [1:0]  r4_k;
    logic        r4_leap;
    logic [DAY_W-1:0] r4_qd;
    // stage 5
    logic [4:0]  r5_a;
    logic [4:0]  r5_h;
    logic [2:0]  r5_l;
    logic        r5_leap;
    logic [DAY_W-1:0] r5_qd;
    // stage 6
    logic        r6_apr;
    logic [DAY_W-1:0] r6_ed;
    logic        r6_leap;
    logic [DAY_W-1:0] r6_qd;
    // stage 7
    logic [DOY_W-1:0] r7_doy;
    logic        r7_leap;
    logic [DAY_W-1:0] r7_qd;
    // stage 8
    logic        r8_leap;
    logic [DAY_W-1:0] r8_qd;
    t_md         r8_easter;
    t_md         r8_friday;
    t_md         r8_ascension;
    t_md         r8_whitsun;
    t_md         r8_carnival;

    logic [29:0] n1_p19;
    logic [9:0]  n1_q19;
    logic [26:0] n1_p100;
    logic [7:0]  n1_b;
    logic [13:0] n2_pf;
    logic [7:0]  n3_gx;
    logic [15:0] n3_pg;
    logic [9:0]  n4_hx;
    logic [19:0] n4_ph;
    logic [4:0]  n4_q30;
    logic [7:0]  n5_lx;
    logic [14:0] n5_pl;
    logic [3:0]  n5_q7;
    logic [8:0]  n6_ms;
    logic [7:0]  n6_v;
    logic        n6_apr;
    logic [7:0]  n7_doy;

    always_comb begin
        adv[STAGES] = !i_stall;
        for (int s = STAGES - 1; s >= 0; s--) begin
            adv[s] = !r_vld[s] || adv[s+1];
        end
    end

    assign o_stall = !adv[0];
    assign o_valid = r_vld[STAGES-1];

    always_comb begin
        n1_p19  = 30'(i_year_value) * 30'(RECIP19);
        n1_q19  = n1_p19[SHIFT19 +: 10];
        n1_p100 = 27'(i_year_value) * 27'(RECIP100);
        n1_b    = n1_p100[SHIFT100 +: 8];

        n2_pf   = 14'(r1_b + 8'd8) * 14'(RECIP25);

        n3_gx   = r2_b - 8'(r2_f) + 8'd1;
        n3_pg   = 16'(n3_gx) * 16'(RECIP3);

        n4_hx   = r3_hs - 10'(r3_g);
        n4_ph   = 20'(n4_hx) * 20'(RECIP30);
        n4_q30  = n4_ph[SHIFT30 +: 5];

        n5_lx   = MJB_PACT + 8'({r4_e, 1'b0}) + 8'({r4_i, 1'b0}) - 8'(r4_h) - 8'(r4_k);
        n5_pl   = 15'(n5_lx) * 15'(RECIP7);
        n5_q7   = n5_pl[SHIFT7 +: 4];

        n6_ms   = 9'(r5_a) + 9'(r5_h) * 9'd11 + 9'(r5_l) * 9'd22;
        n6_v    = 8'(r5_h) + 8'(r5_l) + MJB_BASE - ((n6_ms >= MJB_LIMIT) ? 8'd7 : 8'd0);
        n6_apr  = (n6_v >= APRIL_V);

        n7_doy  = 8'(r6_ed) + 8'(CUM_END[1]) + 8'(r6_leap)
                + (r6_apr ? 8'(MONTH_LEN[2]) : 8'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int s = 1; s < STAGES; s++) begin
                if (adv[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r1_a  <= 5'(i_year_value - 14'(n1_q19) * 14'd19);
            r1_b  <= n1_b;
            r1_c  <= 7'(i_year_value - 14'(n1_b) * 14'd100);
            r1_mq <= i_month_query;
            r1_y4 <= (i_year_value[1:0] == 2'd0);
            r1_yz <= (i_year_value == '0);
        end
        if (adv[1]) begin
            r2_a    <= r1_a;
            r2_b    <= r1_b;
            r2_d    <= r1_b[7:2];
            r2_e    <= r1_b[1:0];
            r2_f    <= n2_pf[SHIFT25 +: 3];
            r2_i    <= r1_c[6:2];
            r2_k    <= r1_c[1:0];
            r2_leap <= !r1_yz && r1_y4 && ((r1_c != '0) || (r1_b[1:0] == 2'd0));
            r2_qd   <= month_days(r1_mq,
                                  !r1_yz && r1_y4 && ((r1_c != '0) || (r1_b[1:0] == 2'd0)));
        end
        if (adv[2]) begin
            r3_a    <= r2_a;
            r3_g    <= n3_pg[SHIFT3 +: 6];
            r3_hs   <= 10'(r2_a) * 10'd19 + 10'(r2_b) - 10'(r2_d) + MJB_EPACT;
            r3_e    <= r2_e;
            r3_i    <= r2_i;
            r3_k    <= r2_k;
            r3_leap <= r2_leap;
            r3_qd   <= r2_qd;
        end
        if (adv[3]) begin
            r4_a    <= r3_a;
            r4_h    <= 5'(n4_hx - 10'(n4_q30) * 10'd30);
            r4_e    <= r3_e;
            r4_i    <= r3_i;
            r4_k    <= r3_k;
            r4_leap <= r3_leap;
            r4_qd   <= r3_qd;
        end
        if (adv[4]) begin
            r5_a    <= r4_a;
            r5_h    <= r4_h;
            r5_l    <= 3'(n5_lx - 8'(n5_q7) * 8'd7);
            r5_leap <= r4_leap;
            r5_qd   <= r4_qd;
        end
        if (adv[5]) begin
            r6_apr  <= n6_apr;
            r6_ed   <= 5'(n6_v - (n6_apr ? APRIL_V : MARCH_V) + 8'd1);
            r6_leap <= r5_leap;
            r6_qd   <= r5_qd;
        end
        if (adv[6]) begin
            r7_doy  <= n7_doy;
            r7_leap <= r6_leap;
            r7_qd   <= r6_qd;
        end
        if (adv[7]) begin
            r8_leap      <= r7_leap;
            r8_qd        <= r7_qd;
            r8_easter    <= split_doy(r7_doy, r7_leap);
            r8_friday    <= split_doy(r7_doy - OFS_FRIDAY, r7_leap);
            r8_ascension <= split_doy(r7_doy + OFS_ASCENSION, r7_leap);
            r8_whitsun   <= split_doy(r7_doy + OFS_WHITSUN, r7_leap);
            r8_carnival  <= split_doy(r7_doy - OFS_CARNIVAL, r7_leap);
        end
    end

    assign o_leap_flag        = r8_leap;
    assign o_query_month_days = r8_qd;
    assign o_easter_month_out = r8_easter.month;
    assign o_easter_day_out   = r8_easter.day;
    assign o_friday_month     = r8_friday.month;
    assign o_friday_day       = r8_friday.day;
    assign o_ascension_month  = r8_ascension.month;
    assign o_ascension_day    = r8_ascension.day;
    assign o_whitsun_month    = r8_whitsun.month;
    assign o_whitsun_day      = r8_whitsun.day;
    assign o_carnival_month   = r8_carnival.month;
    assign o_carnival_day     = r8_carnival.day;

endmodule

[tb/sv/tb_easter_feast_dates.sv]
`timescale 1ns / 1ps

module tb_easter_feast_dates;
    import efd_pkg::*;

    localparam int N_RANDOM    = 850;
    localparam int IDLE_LIMIT  = 2000;
    localparam int SETTLE_CYC  = 20;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [YEAR_W-1:0] year;
        logic [MON_W-1:0]  month;
        bit                drain_first;
    } year_query_t;

    typedef struct packed {
        logic             leap;
        logic [DAY_W-1:0] mdays;
        t_md              easter;
        t_md              friday;
        t_md              ascension;
        t_md              whitsun;
        t_md              carnival;
    } feast_dates_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic drv_valid = 1'b0;
    logic [YEAR_W-1:0] drv_year = '0;
    logic [MON_W-1:0] drv_month = '0;
    logic rcv_stall = 1'b0;

    logic o_stall, o_valid, o_leap_flag;
    logic [DAY_W-1:0] o_query_month_days;
    logic [MON_W-1:0] o_easter_month_out, o_friday_month, o_ascension_month;
    logic [MON_W-1:0] o_whitsun_month, o_carnival_month;
    logic [DAY_W-1:0] o_easter_day_out, o_friday_day, o_ascension_day;
    logic [DAY_W-1:0] o_whitsun_day, o_carnival_day;

    year_query_t  pending_years[$];
    feast_dates_t expected_dates[$];

    int  total_items = 0;
    int  beats_in = 0;
    int  beats_out = 0;
    int  mismatches = 0;
    int  idle_cycles = 0;
    int  cyc = 0;
    int  burst_left = 0;
    int  gap_left = 0;
    logic beat_taken = 1'b0;

    easter_feast_dates uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (drv_valid),
        .o_stall           (o_stall),
        .i_year_value      (drv_year),
        .i_month_query     (drv_month),
        .o_valid           (o_valid),
        .i_stall           (rcv_stall),
        .o_leap_flag       (o_leap_flag),
        .o_query_month_days(o_query_month_days),
        .o_easter_month_out(o_easter_month_out),
        .o_easter_day_out  (o_easter_day_out),
        .o_friday_month    (o_friday_month),
        .o_friday_day      (o_friday_day),
        .o_ascension_month (o_ascension_month),
        .o_ascension_day   (o_ascension_day),
        .o_whitsun_month   (o_whitsun_month),
        .o_whitsun_day     (o_whitsun_day),
        .o_carnival_month  (o_carnival_month),
        .o_carnival_day    (o_carnival_day)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit year_is_leap(int unsigned y);
        return (y != 0) && (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic logic [DAY_W-1:0] length_of_month(int unsigned m, bit leap);
        logic [DAY_W-1:0] len;
        case (m)
            MON_FEB:        len = leap ? 5'd29 : 5'd28;
            4, 6, 9, 11:    len = 5'd30;
            1, 3, 5, 7, 8, 10, 12: len = 5'd31;
            default:        len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic int unsigned easter_day_of_year(int unsigned y, bit leap);
        int unsigned a, b, c, d, e, f, g, h, q, k, l, m, v, mon, doy, j;
        a = y % 19;
        b = y / 100;
        c = y % 100;
        d = b / 4;
        e = b % 4;
        f = (b + 8) / 25;
        g = (b - f + 1) / 3;
        h = (19 * a + b - d - g + 15) % 30;
        q = c / 4;
        k = c % 4;
        l = (32 + 2 * e + 2 * q - h - k) % 7;
        m = (a + 11 * h + 22 * l) / 451;
        v = h + l - 7 * m + 114;
        mon = v / 31;
        doy = v % 31 + 1;
        for (j = 1; j < mon; j++) begin
            doy += length_of_month(j, leap);
        end
        return doy;
    endfunction

    function automatic t_md calendar_date(int unsigned doy, bit leap);
        t_md         md;
        int unsigned m;
        m = 1;
        while (m < 12 && doy > length_of_month(m, leap)) begin
            doy -= length_of_month(m, leap);
            m++;
        end
        md.month = MON_W'(m);
        md.day   = DAY_W'(doy);
        return md;
    endfunction

    function automatic feast_dates_t feast_dates_of(logic [YEAR_W-1:0] year,
                                                    logic [MON_W-1:0] month);
        feast_dates_t fd;
        bit           leap;
        int unsigned  doy;
        leap = year_is_leap(32'(year));
        doy  = easter_day_of_year(32'(year), leap);
        fd.leap      = leap;
        fd.mdays     = length_of_month(32'(month), leap);
        fd.easter    = calendar_date(doy, leap);
        fd.friday    = calendar_date(doy - 2, leap);
        fd.ascension = calendar_date(doy + 39, leap);
        fd.whitsun   = calendar_date(doy + 49, leap);
        fd.carnival  = calendar_date(doy - 49, leap);
        return fd;
    endfunction

    // receiver stall pattern, cycling through four modes chosen by the cycle counter
    always @(negedge i_clk) begin
        cyc <= cyc + 1;
        case ((cyc / 256) % 4)
            0: rcv_stall <= 1'b0;
            1: rcv_stall <= ($urandom_range(0, 9) < 3);
            2: rcv_stall <= ((cyc % 7) < 3);
            default: rcv_stall <= ($urandom_range(0, 9) < 8);
        endcase
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
        end else if (!drv_valid || beat_taken) begin
            if (gap_left > 0) begin
                drv_valid <= 1'b0;
                gap_left  <= gap_left - 1;
            end else if (pending_years.size() == 0) begin
                drv_valid <= 1'b0;
            end else if (pending_years[0].drain_first && expected_dates.size() != 0) begin
                drv_valid <= 1'b0;
            end else begin
                drv_valid <= 1'b1;
                drv_year  <= pending_years[0].year;
                drv_month <= pending_years[0].month;
                void'(pending_years.pop_front());
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        feast_dates_t got, want;
        if (!i_rst_n) begin
            beat_taken <= 1'b0;
        end else begin
            beat_taken <= drv_valid && !o_stall;
            if (drv_valid && !o_stall) begin
                expected_dates.push_back(feast_dates_of(drv_year, drv_month));
                beats_in <= beats_in + 1;
            end
            if (o_valid && !rcv_stall) begin
                beats_out <= beats_out + 1;
                got = '{o_leap_flag, o_query_month_days,
                        '{o_easter_month_out, o_easter_day_out},
                        '{o_friday_month, o_friday_day},
                        '{o_ascension_month, o_ascension_day},
                        '{o_whitsun_month, o_whitsun_day},
                        '{o_carnival_month, o_carnival_day}};
                if (expected_dates.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < MAX_REPORTS)
                        $display("unexpected result beat: %p", got);
                end else begin
                    want = expected_dates.pop_front();
                    if (got !== want) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < MAX_REPORTS)
                            $display("result %0d: expected %p, got %p", beats_out, want, got);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((drv_valid && !o_stall) || (o_valid && !rcv_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("easter_feast_dates: mismatch");
            $finish;
        end
    end

    initial begin
        logic [YEAR_W-1:0] years[20];
        year_query_t       item;
        int                idx;
        years = '{14'd0, 14'd1, 14'd2000, 14'd1900, 14'd2024, 14'd2023, 14'd1818,
                  14'd2285, 14'd1943, 14'd2038, 14'd9999, 14'd16383, 14'd8192,
                  14'd1583, 14'd400, 14'd100, 14'd10000, 14'd5461, 14'd1900, 14'd2000};
        for (idx = 0; idx < 20; idx++) begin
            item.year        = years[idx];
            item.month       = MON_W'(idx);
            item.drain_first = 1'b0;
            pending_years.push_back(item);
        end
        for (idx = 0; idx < N_RANDOM; idx++) begin
            if ($urandom_range(0, 7) == 0)
                item.year = YEAR_W'($urandom_range(0, 16383));
            else
                item.year = YEAR_W'($urandom_range(0, 9999));
            if ($urandom_range(0, 5) == 0)
                item.month = MON_W'($urandom_range(0, 15));
            else
                item.month = MON_W'($urandom_range(1, 12));
            item.drain_first = (idx % 200 == 0);
            pending_years.push_back(item);
        end
        total_items = pending_years.size();

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (!(beats_in == total_items && beats_out == beats_in))
            @(negedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        @(negedge i_clk);

        if (mismatches == 0 && expected_dates.size() == 0) begin
            $display("easter_feast_dates: match");
        end else begin
            $display("easter_feast_dates: mismatch");
        end
        $finish;
    end

endmodule
